### hw/rtl/assert_macros.svh
// Assertion macros for the RTL of the line intersection block; the queue uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// cond must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
        else $error("assertion failed");
// when ante holds, cons must hold in the next cycle
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rstn, cond)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

### hw/rtl/lni_pkg.sv
// Shared types and constants of the line intersection block.
package lni_pkg;

    // result outcome codes
    localparam logic [1:0] OUT_MEET     = 2'd0;
    localparam logic [1:0] OUT_PARALLEL = 2'd1;
    localparam logic [1:0] OUT_SKEW     = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_PAR_TOL  = 2'd0;
    localparam logic [1:0] CFG_SKEW_TOL = 2'd1;

    // queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

    // quotient bits produced by the divider, and the quotient cap
    localparam int QB = 41;
    localparam logic [QB-1:0] QUOT_CAP = {1'b1, {(QB-1){1'b0}}};

    // numerator magnitude width
    localparam int NMAG_W = 67;

    // one input item: two lines, point and direction
    typedef struct packed {
        logic [2:0][15:0] p;
        logic [2:0][15:0] v;
        logic [2:0][15:0] q;
        logic [2:0][15:0] u;
    } t_lines;

    // classified item handed from front to back
    typedef struct packed {
        logic [1:0]        outcome;
        logic [NMAG_W-1:0] nmag;
        logic              nneg;
        logic [63:0]       den;
        logic [2:0][15:0]  p;
        logic [2:0][15:0]  v;
    } t_work;

endpackage

### hw/rtl/lni_front.sv
// Front end: dot products, denominator, triple product and classification.
module lni_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  lni_pkg::t_lines   i_in_data,
    output logic              o_in_ready,
    input  logic [31:0]       i_ptol,
    input  logic [23:0]       i_stol,
    output logic              o_q_push,
    output lni_pkg::t_work    o_q_data,
    input  logic              i_q_full
);

    logic en;

    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_v6;
    lni_pkg::t_lines r_l1, r_l2, r_l3, r_l4, r_l5;
    logic signed [16:0] r_w1 [3];
    logic signed [16:0] r_w2 [3];
    logic signed [16:0] r_w3 [3];

    logic signed [31:0] r_vv2 [3];
    logic signed [31:0] r_vu2 [3];
    logic signed [31:0] r_uu2 [3];
    logic signed [32:0] r_vw2 [3];
    logic signed [32:0] r_uw2 [3];
    logic signed [31:0] r_cr2 [6];

    logic signed [33:0] r_a3, r_b3, r_c3;
    logic signed [34:0] r_d3, r_e3;
    logic signed [32:0] r_cx3 [3];

    logic signed [67:0] r_ac4, r_bb4;
    logic signed [69:0] r_be4, r_cd4;
    logic signed [51:0] r_t4 [3];

    logic [63:0]        r_den5;
    logic signed [69:0] r_num5;
    logic signed [51:0] r_tri5;

    lni_pkg::t_work r_o6;

    logic signed [67:0] den_full;
    logic signed [51:0] tri_mag;
    logic signed [69:0] num_abs;

    // whole front advances together; holds while its last item waits on the queue
    assign en         = !(r_v6 && i_q_full);
    assign o_in_ready = en;
    assign o_q_push   = r_v6 && !i_q_full;
    assign o_q_data   = r_o6;

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_in_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
        end
    end

    // stage 1: w0 = p - q
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_l1 <= i_in_data;
            for (int k = 0; k < 3; k++) begin
                r_w1[k] <= 17'($signed(i_in_data.p[k])) - 17'($signed(i_in_data.q[k]));
            end
        end
    end

    // stage 2: component products
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_l2 <= r_l1;
            for (int k = 0; k < 3; k++) begin
                r_w2[k]  <= r_w1[k];
                r_vv2[k] <= $signed(r_l1.v[k]) * $signed(r_l1.v[k]);
                r_vu2[k] <= $signed(r_l1.v[k]) * $signed(r_l1.u[k]);
                r_uu2[k] <= $signed(r_l1.u[k]) * $signed(r_l1.u[k]);
                r_vw2[k] <= $signed(r_l1.v[k]) * r_w1[k];
                r_uw2[k] <= $signed(r_l1.u[k]) * r_w1[k];
            end
            r_cr2[0] <= $signed(r_l1.v[1]) * $signed(r_l1.u[2]);
            r_cr2[1] <= $signed(r_l1.v[2]) * $signed(r_l1.u[1]);
            r_cr2[2] <= $signed(r_l1.v[2]) * $signed(r_l1.u[0]);
            r_cr2[3] <= $signed(r_l1.v[0]) * $signed(r_l1.u[2]);
            r_cr2[4] <= $signed(r_l1.v[0]) * $signed(r_l1.u[1]);
            r_cr2[5] <= $signed(r_l1.v[1]) * $signed(r_l1.u[0]);
        end
    end

    // stage 3: dot products and cross product
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_l3 <= r_l2;
            for (int k = 0; k < 3; k++) begin
                r_w3[k] <= r_w2[k];
            end
            r_a3 <= 34'(r_vv2[0]) + 34'(r_vv2[1]) + 34'(r_vv2[2]);
            r_b3 <= 34'(r_vu2[0]) + 34'(r_vu2[1]) + 34'(r_vu2[2]);
            r_c3 <= 34'(r_uu2[0]) + 34'(r_uu2[1]) + 34'(r_uu2[2]);
            r_d3 <= 35'(r_vw2[0]) + 35'(r_vw2[1]) + 35'(r_vw2[2]);
            r_e3 <= 35'(r_uw2[0]) + 35'(r_uw2[1]) + 35'(r_uw2[2]);
            r_cx3[0] <= 33'(r_cr2[0]) - 33'(r_cr2[1]);
            r_cx3[1] <= 33'(r_cr2[2]) - 33'(r_cr2[3]);
            r_cx3[2] <= 33'(r_cr2[4]) - 33'(r_cr2[5]);
        end
    end

    // stage 4: second-level products
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_l4  <= r_l3;
            r_ac4 <= r_a3 * r_c3;
            r_bb4 <= r_b3 * r_b3;
            r_be4 <= r_b3 * r_e3;
            r_cd4 <= r_c3 * r_d3;
            for (int k = 0; k < 3; k++) begin
                r_t4[k] <= r_cx3[k] * r_w3[k];
            end
        end
    end

    // stage 5: denominator, numerator, triple product
    assign den_full = r_ac4 - r_bb4;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_l5   <= r_l4;
            r_den5 <= den_full[63:0];
            r_num5 <= r_be4 - r_cd4;
            r_tri5 <= r_t4[0] + r_t4[1] + r_t4[2];
        end
    end

    // stage 6: classify; parallel test wins over skew
    assign tri_mag = r_tri5[51] ? -r_tri5 : r_tri5;
    assign num_abs = r_num5[69] ? -r_num5 : r_num5;

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (r_den5 <= {32'd0, i_ptol}) begin
                r_o6.outcome <= lni_pkg::OUT_PARALLEL;
            end else if (tri_mag > $signed({28'd0, i_stol})) begin
                r_o6.outcome <= lni_pkg::OUT_SKEW;
            end else begin
                r_o6.outcome <= lni_pkg::OUT_MEET;
            end
            r_o6.nmag <= num_abs[lni_pkg::NMAG_W-1:0];
            r_o6.nneg <= r_num5[69];
            r_o6.den  <= r_den5;
            r_o6.p    <= r_l5.p;
            r_o6.v    <= r_l5.v;
        end
    end

endmodule

### hw/rtl/lni_queue.sv
// Short queue of classified items between the front and the back.
`include "assert_macros.svh"

module lni_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  lni_pkg::t_work  i_wr_data,
    output logic            o_full,
    input  logic            i_pop,
    output lni_pkg::t_work  o_rd_data,
    output logic            o_empty
);

    lni_pkg::t_work r_mem [lni_pkg::QDEPTH];
    logic [lni_pkg::QPTR_W-1:0] r_wr, r_rd;
    logic [lni_pkg::QCNT_W-1:0] r_count;

    assign o_full    = (r_count == lni_pkg::QCNT_W'(lni_pkg::QDEPTH));
    assign o_empty   = (r_count == '0);
    assign o_rd_data = r_mem[r_rd];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_wr_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + 1'b1;
            if (i_pop)  r_rd <= r_rd + 1'b1;
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    `ASSERT_ALWAYS(a_no_overflow, i_clk, i_rst_n, !(i_push && o_full))
    `ASSERT_ALWAYS(a_no_underflow, i_clk, i_rst_n, !(i_pop && o_empty))
    `ASSERT_ALWAYS(a_count_range, i_clk, i_rst_n, r_count <= lni_pkg::QCNT_W'(lni_pkg::QDEPTH))
    `ASSERT_NEXT(a_count_up, i_clk, i_rst_n, i_push && !i_pop, r_count == $past(r_count) + 1'b1)

endmodule

### hw/rtl/lni_back.sv
// Back end: scaled numerator, pipelined division, final add and saturation.
module lni_back (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_q_empty,
    input  lni_pkg::t_work         i_q_data,
    output logic                   o_q_pop,
    input  logic                   i_pop,
    output logic                   o_empty,
    output logic [1:0]             o_outcome,
    output logic signed [31:0]     o_meet_x,
    output logic signed [31:0]     o_meet_y,
    output logic signed [31:0]     o_meet_z
);

    localparam int QB = lni_pkg::QB;

    typedef struct packed {
        logic [1:0]       outcome;
        logic [2:0][15:0] p;
        logic [2:0]       vneg;
        logic             nneg;
        logic [63:0]      den;
    } t_ctl;

    typedef struct packed {
        logic          ovf;
        logic [63:0]   rem;
        logic [QB-1:0] lo;
        logic [QB-1:0] q;
    } t_lane;

    logic b_en;

    // stage 0 registers
    logic        r_v0;
    t_ctl        r_c0;
    logic [49:0] r_plo0 [3];
    logic [48:0] r_phi0 [3];

    // divider chain: index 0 is the setup stage, QB is the last step
    logic  r_vd [QB+1];
    t_ctl  r_cd [QB+1];
    t_lane r_ld [QB+1][3];

    // output register
    logic               r_ov;
    logic [1:0]         r_outcome;
    logic signed [31:0] r_meet [3];

    logic [15:0] vmag [3];
    logic [82:0] psum [3];
    logic [90:0] dvd  [3];
    logic signed [42:0] val [3];
    logic [QB-1:0] qt [3];

    // whole back advances unless a result is waiting and not taken
    assign b_en    = !r_ov || i_pop;
    assign o_q_pop = b_en && !i_q_empty;
    assign o_empty = !r_ov;

    // stage 0: |v| times numerator magnitude in two partial products
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            vmag[j] = i_q_data.v[j][15] ? 16'(-$signed(i_q_data.v[j])) : i_q_data.v[j];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (b_en) begin
            r_v0 <= !i_q_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_en) begin
            r_c0.outcome <= i_q_data.outcome;
            r_c0.p       <= i_q_data.p;
            r_c0.nneg    <= i_q_data.nneg;
            r_c0.den     <= i_q_data.den;
            for (int j = 0; j < 3; j++) begin
                r_c0.vneg[j] <= i_q_data.v[j][15];
                r_plo0[j]    <= 50'(i_q_data.nmag[33:0]) * 50'(vmag[j]);
                r_phi0[j]    <= 49'(i_q_data.nmag[66:34]) * 49'(vmag[j]);
            end
        end
    end

    // setup stage: form dividend, detect quotient at or above 2^QB
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            psum[j] = {r_phi0[j], 34'd0} + 83'(r_plo0[j]);
            dvd[j]  = {psum[j], 8'd0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vd[0] <= 1'b0;
        end else if (b_en) begin
            r_vd[0] <= r_v0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_en) begin
            r_cd[0] <= r_c0;
            for (int j = 0; j < 3; j++) begin
                r_ld[0][j].ovf <= ({14'd0, dvd[j][90:QB]} >= r_c0.den);
                r_ld[0][j].rem <= {14'd0, dvd[j][90:QB]};
                r_ld[0][j].lo  <= dvd[j][QB-1:0];
                r_ld[0][j].q   <= '0;
            end
        end
    end

    // restoring division, one quotient bit per stage
    for (genvar k = 0; k < QB; k++) begin : g_div
        t_lane       n_lane [3];
        logic [64:0] trial  [3];
        logic        take   [3];

        always_comb begin
            for (int j = 0; j < 3; j++) begin
                trial[j]      = {r_ld[k][j].rem, r_ld[k][j].lo[QB-1-k]};
                take[j]       = trial[j] >= {1'b0, r_cd[k].den};
                n_lane[j].ovf = r_ld[k][j].ovf;
                n_lane[j].lo  = r_ld[k][j].lo;
                n_lane[j].rem = take[j] ? 64'(trial[j] - {1'b0, r_cd[k].den})
                                        : trial[j][63:0];
                n_lane[j].q   = {r_ld[k][j].q[QB-2:0], take[j]};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vd[k+1] <= 1'b0;
            end else if (b_en) begin
                r_vd[k+1] <= r_vd[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (b_en) begin
                r_cd[k+1] <= r_cd[k];
                for (int j = 0; j < 3; j++) begin
                    r_ld[k+1][j] <= n_lane[j];
                end
            end
        end
    end

    // final: cap quotient, apply sign, add point, saturate; non-meet outcomes give zero
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            if (r_ld[QB][j].ovf || (r_ld[QB][j].q > lni_pkg::QUOT_CAP)) begin
                qt[j] = lni_pkg::QUOT_CAP;
            end else begin
                qt[j] = r_ld[QB][j].q;
            end
            val[j] = 43'($signed({r_cd[QB].p[j], 8'd0}))
                   + ((r_cd[QB].nneg != r_cd[QB].vneg[j]) ? -$signed({2'b00, qt[j]})
                                                          : $signed({2'b00, qt[j]}));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (b_en) begin
            r_ov <= r_vd[QB];
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_en) begin
            r_outcome <= r_cd[QB].outcome;
            for (int j = 0; j < 3; j++) begin
                if (r_cd[QB].outcome != lni_pkg::OUT_MEET) begin
                    r_meet[j] <= '0;
                end else if (val[j] > 43'sd2147483647) begin
                    r_meet[j] <= 32'sh7FFFFFFF;
                end else if (val[j] < -43'sd2147483648) begin
                    r_meet[j] <= 32'sh80000000;
                end else begin
                    r_meet[j] <= val[j][31:0];
                end
            end
        end
    end

    assign o_outcome = r_outcome;
    assign o_meet_x  = r_meet[0];
    assign o_meet_y  = r_meet[1];
    assign o_meet_z  = r_meet[2];

endmodule

### hw/rtl/line_intersection_3d_core.sv
// Top level of the 3D line-line intersection block.
//
// Input queue side: drive the twelve Q8.8 line fields with push high; the
// item is taken at an edge where push is high and full is low.
// Result queue side: while empty is low, outcome and meet_x/y/z hold the
// oldest result; it is taken at an edge where pop is high.
// Config channel: i_cfg_valid with i_cfg_index and i_cfg_data, o_cfg_ready
// is always high. Index 0 is the parallel tolerance, 1 the skew tolerance.
// Throughput: one item per cycle while no stall holds the pipeline; the divider is fully pipelined.
// Path from accept to result: six front stages, the classified-item queue,
// two setup stages, 41 divider steps and the output register.
// Reset clears all valid flags, the queue and both tolerances to zero.
// When the receiver stalls, the back pipeline holds, the queue fills, then
// the front holds and full goes high; no item is dropped.
module line_intersection_3d_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic signed [15:0] i_first_point_x,
    input  logic signed [15:0] i_first_point_y,
    input  logic signed [15:0] i_first_point_z,
    input  logic signed [15:0] i_first_dir_x,
    input  logic signed [15:0] i_first_dir_y,
    input  logic signed [15:0] i_first_dir_z,
    input  logic signed [15:0] i_second_point_x,
    input  logic signed [15:0] i_second_point_y,
    input  logic signed [15:0] i_second_point_z,
    input  logic signed [15:0] i_second_dir_x,
    input  logic signed [15:0] i_second_dir_y,
    input  logic signed [15:0] i_second_dir_z,
    output logic               empty,
    input  logic               pop,
    output logic [1:0]         o_outcome,
    output logic signed [31:0] o_meet_x,
    output logic signed [31:0] o_meet_y,
    output logic signed [31:0] o_meet_z,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);

    logic [31:0] r_ptol;
    logic [23:0] r_stol;

    lni_pkg::t_lines in_data;
    lni_pkg::t_work  wr_data, rd_data;
    logic in_ready, q_push, q_full, q_pop, q_empty;

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptol <= '0;
            r_stol <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                lni_pkg::CFG_PAR_TOL:  r_ptol <= i_cfg_data;
                lni_pkg::CFG_SKEW_TOL: r_stol <= i_cfg_data[23:0];
                default: ;
            endcase
        end
    end

    // pack input fields
    assign in_data.p = {i_first_point_z, i_first_point_y, i_first_point_x};
    assign in_data.v = {i_first_dir_z, i_first_dir_y, i_first_dir_x};
    assign in_data.q = {i_second_point_z, i_second_point_y, i_second_point_x};
    assign in_data.u = {i_second_dir_z, i_second_dir_y, i_second_dir_x};
    assign full      = !in_ready;

    lni_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (push),
        .i_in_data  (in_data),
        .o_in_ready (in_ready),
        .i_ptol     (r_ptol),
        .i_stol     (r_stol),
        .o_q_push   (q_push),
        .o_q_data   (wr_data),
        .i_q_full   (q_full)
    );

    lni_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (q_push),
        .i_wr_data (wr_data),
        .o_full    (q_full),
        .i_pop     (q_pop),
        .o_rd_data (rd_data),
        .o_empty   (q_empty)
    );

    lni_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_q_data  (rd_data),
        .o_q_pop   (q_pop),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_outcome (o_outcome),
        .o_meet_x  (o_meet_x),
        .o_meet_y  (o_meet_y),
        .o_meet_z  (o_meet_z)
    );

endmodule

### dv/line_intersection_3d_core_tb.sv
// Testbench for the 3D line intersection core: directed and random line pairs, self-checking.
`timescale 1ns / 100ps

module line_intersection_3d_core_tb;

    // config indexes that select no register
    localparam logic [1:0] CFG_SPARE = 2'd2;
    localparam logic [1:0] CFG_NONE  = 2'd3;
    localparam int DRAIN_CYCLES = 80;

    typedef struct {
        logic [1:0]        outcome;
        logic signed [31:0] meet [3];
    } t_meet;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               push = 1'b0;
    logic               full;
    logic signed [15:0] lane [12];
    logic               empty;
    logic               pop = 1'b0;
    logic [1:0]         o_outcome;
    logic signed [31:0] o_meet_x, o_meet_y, o_meet_z;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [1:0]         i_cfg_index = '0;
    logic [31:0]        i_cfg_data = '0;

    // tolerances as the block should hold them
    logic [31:0] par_tol = '0;
    logic [23:0] skew_tol = '0;

    t_meet meet_q [$];
    int    n_fail = 0;
    int    stall_req = 0;

    initial for (int k = 0; k < 12; k++) lane[k] = '0;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    line_intersection_3d_core u_dut (
        .i_clk, .i_rst_n, .push, .full,
        .i_first_point_x(lane[0]), .i_first_point_y(lane[1]), .i_first_point_z(lane[2]),
        .i_first_dir_x(lane[3]), .i_first_dir_y(lane[4]), .i_first_dir_z(lane[5]),
        .i_second_point_x(lane[6]), .i_second_point_y(lane[7]), .i_second_point_z(lane[8]),
        .i_second_dir_x(lane[9]), .i_second_dir_y(lane[10]), .i_second_dir_z(lane[11]),
        .empty, .pop, .o_outcome, .o_meet_x, .o_meet_y, .o_meet_z,
        .i_cfg_valid, .o_cfg_ready, .i_cfg_index, .i_cfg_data
    );

    // closest-point solve, exact wide integer arithmetic
    function automatic t_meet solve_lines(logic signed [15:0] f [12]);
        logic signed [127:0] p [3], v [3], q [3], u [3], w [3];
        logic signed [127:0] a, b, c, d, e, den, cx, cy, cz, trip, num, nmag, vmag, qt, val;
        logic neg, qneg;
        t_meet r;
        a = '0; b = '0; c = '0; d = '0; e = '0;
        for (int i = 0; i < 3; i++) begin
            p[i] = 128'(f[i]); v[i] = 128'(f[3+i]); q[i] = 128'(f[6+i]); u[i] = 128'(f[9+i]);
            w[i] = p[i] - q[i];
            r.meet[i] = '0;
        end
        for (int i = 0; i < 3; i++) begin
            a += v[i] * v[i]; b += v[i] * u[i]; c += u[i] * u[i];
            d += v[i] * w[i]; e += u[i] * w[i];
        end
        den = a * c - b * b;
        if (den <= $signed({96'b0, par_tol})) begin
            r.outcome = lni_pkg::OUT_PARALLEL;
            return r;
        end
        cx = v[1] * u[2] - v[2] * u[1];
        cy = v[2] * u[0] - v[0] * u[2];
        cz = v[0] * u[1] - v[1] * u[0];
        trip = cx * w[0] + cy * w[1] + cz * w[2];
        if (trip < 0) trip = -trip;
        if (trip > $signed({104'b0, skew_tol})) begin
            r.outcome = lni_pkg::OUT_SKEW;
            return r;
        end
        r.outcome = lni_pkg::OUT_MEET;
        num = b * e - c * d;
        neg = num < 0;
        nmag = neg ? -num : num;
        for (int i = 0; i < 3; i++) begin
            vmag = v[i] < 0 ? -v[i] : v[i];
            qt = (nmag * (vmag * 256)) / den;
            if (qt > (128'sd1 <<< 40)) qt = 128'sd1 <<< 40;
            qneg = neg != (v[i] < 0);
            val = p[i] * 256 + (qneg ? -qt : qt);
            if (val > 128'sd2147483647) val = 128'sd2147483647;
            if (val < -128'sd2147483648) val = -128'sd2147483648;
            r.meet[i] = val[31:0];
        end
        return r;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // offer one item, hold until taken; caller sits at a falling edge
    task automatic send_lines(logic signed [15:0] f [12], bit no_gap = 0);
        int g;
        g = no_gap ? 0 : pick_gap();
        if (g > 0) begin
            push = 1'b0;
            repeat (g) @(negedge i_clk);
        end
        push = 1'b1;
        for (int k = 0; k < 12; k++) lane[k] = f[k];
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        meet_q.push_back(solve_lines(f));
        @(negedge i_clk);
    endtask

    // let every expected result come back, then the pipeline settle
    task automatic drain_all();
        push = 1'b0;
        while (meet_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_cfg(logic [1:0] idx, logic [31:0] data);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx == lni_pkg::CFG_PAR_TOL) par_tol = data;
        else if (idx == lni_pkg::CFG_SKEW_TOL) skew_tol = data[23:0];
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    function automatic logic signed [15:0] rnd16();
        return 16'($urandom());
    endfunction

    // lines through a common point, or parallel, or arbitrary
    task automatic send_random(int count);
        logic signed [15:0] f [12];
        logic signed [15:0] m [3];
        int kind, k1, k2, sc;
        for (int n = 0; n < count; n++) begin
            kind = $urandom_range(0, 9);
            sc = $urandom_range(0, 2);
            for (int i = 0; i < 3; i++) begin
                m[i] = (sc == 0) ? rnd16()
                                 : 16'($signed(16'($urandom_range(0, 1023))) - 512);
                f[3+i] = (sc == 2) ? 16'($signed(16'($urandom_range(0, 63))) - 32) : rnd16();
                f[9+i] = (sc == 2) ? 16'($signed(16'($urandom_range(0, 63))) - 32) : rnd16();
            end
            k1 = $urandom_range(0, 6) - 3;
            k2 = $urandom_range(0, 6) - 3;
            for (int i = 0; i < 3; i++) begin
                if (kind < 6) begin
                    f[i] = 16'(m[i] + k1 * f[3+i]);
                    f[6+i] = 16'(m[i] + k2 * f[9+i]);
                end else if (kind < 7) begin
                    f[9+i] = 16'(k2 * f[3+i]);
                    f[i] = m[i];
                    f[6+i] = rnd16();
                end else begin
                    f[i] = rnd16();
                    f[6+i] = rnd16();
                end
            end
            send_lines(f);
        end
    endtask

    // corners of the field ranges and the named special cases
    task automatic test_directed();
        logic signed [15:0] f [12];
        for (int k = 0; k < 12; k++) f[k] = 16'sh7FFF;
        send_lines(f);
        for (int k = 0; k < 12; k++) f[k] = -16'sh8000;
        send_lines(f);
        for (int k = 0; k < 12; k++) f[k] = (k % 2) ? 16'sh7FFF : -16'sh8000;
        send_lines(f);
        for (int k = 0; k < 12; k++) f[k] = (k % 3) ? -16'sh8000 : 16'sh7FFF;
        send_lines(f);
        // zero direction on one line
        f = '{16'sd256, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
              16'sd0, 16'sd0, 16'sd0, 16'sd256, 16'sd0, 16'sd0};
        send_lines(f);
        // parallel distinct lines
        f = '{16'sd0, 16'sd0, 16'sd0, 16'sd256, 16'sd0, 16'sd0,
              16'sd0, 16'sd256, 16'sd0, -16'sd512, 16'sd0, 16'sd0};
        send_lines(f);
        // clean crossing at (1,1,0)
        f = '{16'sd0, 16'sd256, 16'sd0, 16'sd256, 16'sd0, 16'sd0,
              16'sd256, 16'sd0, 16'sd0, 16'sd0, 16'sd256, 16'sd0};
        send_lines(f);
        // skew: offset in z
        f = '{16'sd0, 16'sd0, 16'sd256, 16'sd256, 16'sd0, 16'sd0,
              16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd256, 16'sd0};
        send_lines(f);
        // nearly parallel, far meet: saturation
        f = '{16'sh7F00, -16'sh8000, 16'sd0, 16'sh7FFF, 16'sd1, 16'sd0,
              -16'sh8000, 16'sh7F00, 16'sd0, 16'sh7FFF, 16'sd0, 16'sd0};
        send_lines(f);
        f = '{-16'sh8000, 16'sh7FFF, 16'sd0, -16'sh8000, -16'sd1, 16'sd0,
              16'sh7FFF, -16'sh8000, 16'sd0, 16'sh7FFF, 16'sd0, 16'sd0};
        send_lines(f);
        // small skew offset, caught or not by the tolerance
        f = '{16'sd0, 16'sd0, 16'sd1, 16'sd1, 16'sd0, 16'sd0,
              16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd1, 16'sd0};
        send_lines(f);
        // den of exactly one unit
        f = '{16'sd5, 16'sd7, 16'sd0, 16'sd1, 16'sd0, 16'sd0,
              16'sd3, 16'sd2, 16'sd0, 16'sd0, 16'sd1, 16'sd0};
        send_lines(f);
    endtask

    task automatic test_reset_tolerances();
        test_directed();
        send_random(150);
        drain_all();
    endtask

    task automatic test_max_tolerances();
        write_cfg(lni_pkg::CFG_PAR_TOL, 32'hFFFF_FFFF);
        write_cfg(lni_pkg::CFG_SKEW_TOL, 32'hFFFF_FFFF);
        test_directed();
        send_random(60);
        drain_all();
    endtask

    task automatic test_mid_tolerances();
        write_cfg(lni_pkg::CFG_PAR_TOL, $urandom_range(1, 255));
        write_cfg(lni_pkg::CFG_SKEW_TOL, 32'h0000_0001);
        write_cfg(CFG_NONE, 32'h0000_FFFF);
        write_cfg(CFG_SPARE, 32'hFFFF_FFFF);
        test_directed();
        send_random(150);
        drain_all();
        write_cfg(lni_pkg::CFG_PAR_TOL, $urandom());
        write_cfg(lni_pkg::CFG_SKEW_TOL, $urandom_range(0, 24'hFFFFFF));
        send_random(150);
        drain_all();
    endtask

    // receiver stops for a long stretch while items keep coming
    task automatic test_backpressure();
        logic signed [15:0] f [12];
        write_cfg(lni_pkg::CFG_PAR_TOL, 32'd0);
        write_cfg(lni_pkg::CFG_SKEW_TOL, 32'd0);
        stall_req = 300;
        for (int n = 0; n < 80; n++) begin
            for (int k = 0; k < 12; k++) f[k] = rnd16();
            send_lines(f, 1);
        end
        drain_all();
    endtask

    task automatic test_random_bulk();
        send_random(200);
        drain_all();
    endtask

    // result side: random-length pauses, with a counted hold when asked
    initial begin
        int g;
        forever begin
            @(negedge i_clk);
            if (stall_req > 0) begin
                pop = 1'b0;
                repeat (stall_req) @(negedge i_clk);
                stall_req = 0;
            end else begin
                g = pick_gap();
                if (g > 0) begin
                    pop = 1'b0;
                    repeat (g) @(negedge i_clk);
                end
                pop = 1'b1;
            end
        end
    end

    // compare each popped result with the oldest prediction
    always @(posedge i_clk) begin
        t_meet x;
        if (i_rst_n && pop && !empty) begin
            if (meet_q.size() == 0) begin
                n_fail++;
                if (n_fail <= 10) $display("unexpected result: outcome %0d", o_outcome);
            end else begin
                x = meet_q.pop_front();
                if (x.outcome !== o_outcome || x.meet[0] !== o_meet_x ||
                    x.meet[1] !== o_meet_y || x.meet[2] !== o_meet_z) begin
                    n_fail++;
                    if (n_fail <= 10)
                        $display("mismatch: exp %0d (%0d,%0d,%0d) got %0d (%0d,%0d,%0d)",
                                 x.outcome, x.meet[0], x.meet[1], x.meet[2],
                                 o_outcome, o_meet_x, o_meet_y, o_meet_z);
                end
            end
        end
    end

    initial begin
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);
        test_reset_tolerances();
        test_max_tolerances();
        test_mid_tolerances();
        test_backpressure();
        test_random_bulk();
        if (n_fail == 0 && meet_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // run limit
    initial begin
        #10_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/lni_pkg.sv
hw/rtl/lni_front.sv
hw/rtl/lni_queue.sv
hw/rtl/lni_back.sv
hw/rtl/line_intersection_3d_core.sv
dv/line_intersection_3d_core_tb.sv
